>>> design/emv_pkg.sv
package emv_pkg;

	// Field widths
	localparam int ANGLE_W  = 12;
	localparam int TURN_W   = 20;
	localparam int TICK_W   = 32;
	localparam int THRESH_W = 16;
	localparam int VEL_W    = 32;

	// Stream word layout
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 64;

	// Derived arithmetic widths
	localparam int DELTA_W = ANGLE_W + 1;
	localparam int POS_W   = TURN_W + ANGLE_W + 1;
	localparam int MAG_W   = POS_W;
	localparam int SCALE_W = 10;
	localparam int PROD_W  = MAG_W + SCALE_W;
	localparam int REM_W   = TICK_W + 1;
	localparam int CNT_W   = $clog2(PROD_W);

	localparam logic [SCALE_W-1:0]  VEL_SCALE     = SCALE_W'(1000);
	localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(3276);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Input kind carried on tuser
	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	// Work item handed from front to back
	typedef struct packed {
		logic                is_vel;
		logic                neg;
		logic [MAG_W-1:0]    mag;
		logic [TICK_W-1:0]   dt;
		logic [TURN_W-1:0]   turns;
		logic [ANGLE_W-1:0]  angle;
	} emv_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_SAT
	} bk_state_t;

endpackage

>>> design/encoder_multiturn_velocity_unit.sv
// Channel   Dir  Word                                        Side band
// s_*       in   tdata: abs_angle[11:0], tick_ms[43:12]      tuser: action
// m_*       out  tdata: turns[19:0], angle[31:20],           tuser: velocity_valid
//                       velocity[63:32]
// cfg_*     in   cfg_wdata: wrap_threshold                   cfg_we: write strobe
//
// An angle sample is stored in the queue and then registered at the output.
// In the back end a velocity request goes through one scaling multiply,
// then a restoring divider that resolves one quotient bit per cycle over 43 bits.
// A two-word queue sits between front and back; samples keep flowing in while
// the divider runs, until the queue fills.
// arst_n clears all position state, the snapshot and the queue, and loads the
// wrap threshold with 3276.
module encoder_multiturn_velocity_unit
	import emv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // abs_angle, tick_ms, zero pad
	input  logic                 s_tuser,   // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // turns, angle, velocity
	output logic                 m_tuser,   // velocity_valid
	input  logic                 cfg_we,
	input  logic [THRESH_W-1:0]  cfg_wdata
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	emv_item_t  q_in;
	emv_item_t  q_head;

	emv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_in)
	);

	emv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	emv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Never write a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue written while full");

	// Never read an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue read while empty");

	// A sample result carries zero velocity
	a_sample_vel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ACT_SAMPLE)) |-> (m_tdata[M_DATA_W-1:TURN_W+ANGLE_W] == '0))
		else $error("sample result with nonzero velocity");

endmodule

>>> design/emv_front.sv
module emv_front
	import emv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic                 s_tuser,
	input  logic                 cfg_we,
	input  logic [THRESH_W-1:0]  cfg_wdata,
	input  logic                 q_full,
	output logic                 q_push,
	output emv_item_t            q_item
);

	logic                 seen_q;
	logic [ANGLE_W-1:0]   last_angle_q;
	logic [TURN_W-1:0]    turn_q;
	logic [TICK_W-1:0]    last_tick_q;
	logic [ANGLE_W-1:0]   snap_angle_q;
	logic [TURN_W-1:0]    snap_turns_q;
	logic [TICK_W-1:0]    snap_tick_q;
	logic [THRESH_W-1:0]  thresh_q;

	logic [ANGLE_W-1:0]   raw;
	logic [TICK_W-1:0]    tick;
	logic [DELTA_W-1:0]   delta;
	logic [DELTA_W-1:0]   adelta;
	logic                 wrap;
	logic [TURN_W-1:0]    turn_nxt;
	logic [TURN_W-1:0]    dturn;
	logic [DELTA_W-1:0]   dang;
	logic [POS_W-1:0]     dpos;
	logic                 neg;
	logic [TICK_W-1:0]    dt_raw;
	logic                 is_req;

	assign raw    = s_tdata[ANGLE_W-1:0];
	assign tick   = s_tdata[ANGLE_W+TICK_W-1:ANGLE_W];
	assign is_req = (s_tuser == ACT_REQUEST);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Wrap test on the sample step
	always_comb begin
		delta  = {1'b0, raw} - {1'b0, last_angle_q};
		adelta = delta[DELTA_W-1] ? (~delta + DELTA_W'(1)) : delta;
		wrap   = THRESH_W'(adelta) > thresh_q;
		turn_nxt = turn_q;
		if (seen_q && wrap) begin
			turn_nxt = delta[DELTA_W-1] ? (turn_q + TURN_W'(1)) : (turn_q - TURN_W'(1));
		end
	end

	// Position change and elapsed time since the snapshot
	always_comb begin
		dturn  = turn_q - snap_turns_q;
		dang   = {1'b0, last_angle_q} - {1'b0, snap_angle_q};
		dpos   = {dturn[TURN_W-1], dturn, {ANGLE_W{1'b0}}}
		       + {{(POS_W-DELTA_W){dang[DELTA_W-1]}}, dang};
		neg    = dpos[POS_W-1];
		dt_raw = last_tick_q - snap_tick_q;
	end

	// Build the queue word
	always_comb begin
		q_item        = '0;
		q_item.is_vel = is_req;
		if (is_req) begin
			q_item.neg   = neg;
			q_item.mag   = neg ? (~dpos + MAG_W'(1)) : dpos;
			q_item.dt    = (dt_raw == '0) ? TICK_W'(1) : dt_raw;
			q_item.turns = turn_q;
			q_item.angle = last_angle_q;
		end else begin
			q_item.turns = turn_nxt;
			q_item.angle = raw;
		end
	end

	// Update threshold, position and snapshot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_angle_q <= '0;
			turn_q       <= '0;
			last_tick_q  <= '0;
			snap_angle_q <= '0;
			snap_turns_q <= '0;
			snap_tick_q  <= '0;
			thresh_q     <= THRESH_RESET;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (q_push) begin
				if (is_req) begin
					snap_angle_q <= last_angle_q;
					snap_turns_q <= turn_q;
					snap_tick_q  <= last_tick_q;
				end else begin
					seen_q       <= 1'b1;
					last_angle_q <= raw;
					turn_q       <= turn_nxt;
					if (seen_q) begin
						last_tick_q <= tick;
					end
				end
			end
		end
	end

endmodule

>>> design/emv_queue.sv
module emv_queue
	import emv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  emv_item_t  push_item,
	output logic       full,
	input  logic       pop,
	output emv_item_t  head,
	output logic       empty
);

	emv_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/emv_back.sv
module emv_back
	import emv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  emv_item_t            q_head,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,
	output logic                 m_tuser
);

	localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(PROD_W - 1);
	localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'h8000_0000);
	localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(64'h7FFF_FFFF);

	bk_state_t            state_q, state_nxt;
	logic                 neg_q;
	logic [MAG_W-1:0]     mag_q;
	logic [TICK_W-1:0]    dt_q;
	logic [TURN_W-1:0]    turns_q;
	logic [ANGLE_W-1:0]   angle_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [M_DATA_W-1:0]  out_data_q;
	logic                 out_user_q;

	logic                 out_free;
	logic                 load_sample;
	logic                 load_req;
	logic                 load_vel;
	logic [REM_W-1:0]     rem_sh;
	logic                 ge;
	logic [VEL_W-1:0]     vel_sat;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: if (!q_empty && q_head.is_vel) state_nxt = BK_MUL;
			BK_MUL:  state_nxt = BK_DIV;
			BK_DIV:  if (cnt_q == LAST_STEP) state_nxt = BK_SAT;
			BK_SAT:  if (out_free) state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		load_sample = 1'b0;
		load_req    = 1'b0;
		load_vel    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				load_sample = !q_empty && !q_head.is_vel && out_free;
				load_req    = !q_empty && q_head.is_vel;
			end
			BK_SAT:  load_vel = out_free;
			default: ;
		endcase
		q_pop = load_sample || load_req;
	end

	// One quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q[REM_W-2:0], dvd_q[PROD_W-1]};
		ge     = rem_sh >= {1'b0, dt_q};
	end

	// Saturate the quotient to the signed result range
	always_comb begin
		if (neg_q) begin
			vel_sat = (dvd_q > NEG_LIMIT) ? VEL_W'(32'h8000_0000)
			                              : (~dvd_q[VEL_W-1:0] + VEL_W'(1));
		end else begin
			vel_sat = (dvd_q > POS_LIMIT) ? VEL_W'(32'h7FFF_FFFF) : dvd_q[VEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Request operands, scale and divide
	always_ff @(posedge clk) begin
		if (load_req) begin
			neg_q   <= q_head.neg;
			mag_q   <= q_head.mag;
			dt_q    <= q_head.dt;
			turns_q <= q_head.turns;
			angle_q <= q_head.angle;
		end
		case (state_q)
			BK_MUL: begin
				dvd_q <= PROD_W'(mag_q) * PROD_W'(VEL_SCALE);
				rem_q <= '0;
				cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q <= ge ? (rem_sh - {1'b0, dt_q}) : rem_sh;
				dvd_q <= {dvd_q[PROD_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_sample || load_vel) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sample) begin
			out_data_q <= {VEL_W'(0), q_head.angle, q_head.turns};
			out_user_q <= ACT_SAMPLE;
		end else if (load_vel) begin
			out_data_q <= {vel_sat, angle_q, turns_q};
			out_user_q <= ACT_REQUEST;
		end
	end

endmodule
